FILE: rtl/gvq_pkg.sv
// ----------------------------------------------------------------------------
// gvq_pkg
// Shared constants, types and helpers of the grid value quantizer.
// ----------------------------------------------------------------------------
`default_nettype none
package gvq_pkg;

  localparam int MAX_RANGE_DIMS = 8;
  localparam int MAX_SET_DIMS   = 8;
  localparam int SET_DEPTH      = 16;
  localparam int VALUE_WIDTH    = 32;

  localparam int RIDX_W = (MAX_RANGE_DIMS > 1) ? $clog2(MAX_RANGE_DIMS) : 1;
  localparam int SIDX_W = (MAX_SET_DIMS > 1) ? $clog2(MAX_SET_DIMS) : 1;
  localparam int EIDX_W = $clog2(SET_DEPTH);
  localparam int LEN_W  = $clog2(SET_DEPTH + 1);
  localparam int TBL_DEPTH = MAX_SET_DIMS * SET_DEPTH;
  localparam int ADDR_W = $clog2(TBL_DEPTH);
  localparam int DCNT_W = $clog2(VALUE_WIDTH);

  // configuration register indexes
  localparam logic [1:0] REG_RANGE_DIM_COUNT = 2'd0;
  localparam logic [1:0] REG_SET_DIM_COUNT   = 2'd1;

  typedef enum logic [1:0] {
    REQ_LOAD_RANGE = 2'd0,
    REQ_LOAD_LEN   = 2'd1,
    REQ_LOAD_ENTRY = 2'd2,
    REQ_QUANTIZE   = 2'd3
  } req_type_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_LOAD,
    ST_RNG_WR,
    ST_DIV_QUANT,
    ST_SET_T0,
    ST_SET_TL,
    ST_SET_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [VALUE_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quot;
    logic [VALUE_WIDTH-1:0] rem;
  } div_rsp_t;

  // nearer of two neighbors, tie goes up
  function automatic logic signed [VALUE_WIDTH-1:0] pick_nearer(
    input logic signed [VALUE_WIDTH-1:0] v,
    input logic signed [VALUE_WIDTH-1:0] lo,
    input logic signed [VALUE_WIDTH-1:0] hi
  );
    logic [VALUE_WIDTH-1:0] dlo;
    logic [VALUE_WIDTH-1:0] dhi;
    dlo = VALUE_WIDTH'(v - lo);
    dhi = VALUE_WIDTH'(hi - v);
    return (dlo < dhi) ? lo : hi;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/gvq_in_if.sv
// ----------------------------------------------------------------------------
// gvq_in_if
// Request channel of the grid value quantizer.
// ----------------------------------------------------------------------------
`default_nettype none
interface gvq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [3:0]         dim;
  logic [3:0]         entry_index;
  logic signed [31:0] value;
  logic signed [31:0] range_upper;
  logic [15:0]        step_count;
  logic [4:0]         set_length;

  modport source (output valid, req_type, dim, entry_index, value, range_upper,
                  step_count, set_length, input ready);
  modport sink (input valid, req_type, dim, entry_index, value, range_upper,
                step_count, set_length, output ready);
endinterface
`default_nettype wire

FILE: rtl/gvq_out_if.sv
// ----------------------------------------------------------------------------
// gvq_out_if
// Result channel of the grid value quantizer.
// ----------------------------------------------------------------------------
`default_nettype none
interface gvq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] quantized;
  logic               status;

  modport source (output valid, quantized, status, input ready);
  modport sink (input valid, quantized, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/gvq_ram.sv
// ----------------------------------------------------------------------------
// gvq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module gvq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/gvq_divider.sv
// ----------------------------------------------------------------------------
// gvq_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module gvq_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gvq_pkg::div_req_t req_i,
  output gvq_pkg::div_rsp_t      rsp_o
);
  import gvq_pkg::*;

  logic                   busy_q, done_q;
  logic [DCNT_W-1:0]      cnt_q;
  logic [VALUE_WIDTH-1:0] q_q, r_q, d_q;
  logic [VALUE_WIDTH-1:0] q_d, r_d;
  logic [VALUE_WIDTH:0]   trial;
  logic                   ge;

  always_comb begin
    trial = {r_q, q_q[VALUE_WIDTH-1]};
    ge    = trial >= {1'b0, d_q};
    r_d   = ge ? VALUE_WIDTH'(trial - {1'b0, d_q}) : trial[VALUE_WIDTH-1:0];
    q_d   = {q_q[VALUE_WIDTH-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DCNT_W'(VALUE_WIDTH - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      q_q <= req_i.dividend;
      r_q <= '0;
      d_q <= req_i.divisor;
    end else if (busy_q) begin
      q_q <= q_d;
      r_q <= r_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = q_q;
  assign rsp_o.rem  = r_q;
endmodule
`default_nettype wire

FILE: rtl/grid_value_quantizer_unit.sv
// ----------------------------------------------------------------------------
// grid_value_quantizer_unit
// Snaps Q16.16 values to the nearest point of a range or set dimension.
// ----------------------------------------------------------------------------
// One request at a time. Range loads and range quantizes both go through the
// bit-serial divider (step at load, grid index at quantize); a load with max at
// or below min skips it. A set quantize reads the table of n entries from the
// entry RAM, one table read per cycle. Set loads are written on acceptance;
// clamped values and bad dimensions go straight to the finish state. A finished
// result sits in an output register, so a new request is taken while it waits
// to be read.
`default_nettype none
module grid_value_quantizer_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [3:0] cfg_data_i,
  gvq_in_if.sink          in_if,
  gvq_out_if.source       out_if
);
  import gvq_pkg::*;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;

  state_e state_q, state_d;
  logic [3:0] range_cnt_q, set_cnt_q;

  val_t                   rlo_q [MAX_RANGE_DIMS];
  val_t                   rhi_q [MAX_RANGE_DIMS];
  logic [VALUE_WIDTH-1:0] rstep_q [MAX_RANGE_DIMS];
  logic [LEN_W-1:0]       slen_q [MAX_SET_DIMS];

  val_t v_q, v_d, up_q, up_d;
  logic [RIDX_W-1:0] ridx_q, ridx_d;
  logic [ADDR_W-1:0] sbase_q, sbase_d;
  logic [LEN_W-1:0]  n_q, n_d;
  logic [VALUE_WIDTH-1:0] step_q, step_d;
  val_t t0_q, t0_d, tl_q, tl_d, below_q, below_d, res_q, res_d;
  logic [EIDX_W-1:0] i_q, i_d;
  logic stat_q, stat_d;
  logic ov_q, ov_d;
  val_t oq_q;
  logic ost_q;

  logic in_acc;
  logic [4:0] rc, sc, dim5, s5;
  logic is_rng, is_set;
  logic [RIDX_W-1:0] ridx_in;
  logic [SIDX_W-1:0] sidx_in;
  logic [ADDR_W-1:0] base_in;
  logic [15:0] cnt_in;
  logic [LEN_W-1:0] len_in;
  logic wr_len, ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;
  val_t ent;
  div_req_t div_req;
  div_rsp_t div_rsp;
  val_t below_r, above_r, lo_r, hi_r;
  logic [VALUE_WIDTH-1:0] gap_r, st_r, q_r;

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;

  always_comb begin
    rc = (5'(range_cnt_q) > 5'(MAX_RANGE_DIMS)) ? 5'(MAX_RANGE_DIMS) : 5'(range_cnt_q);
    sc = (5'(set_cnt_q) > 5'(MAX_SET_DIMS)) ? 5'(MAX_SET_DIMS) : 5'(set_cnt_q);
    dim5    = {1'b0, in_if.dim};
    is_rng  = dim5 < rc;
    s5      = dim5 - rc;
    is_set  = !is_rng && (s5 < sc);
    ridx_in = in_if.dim[RIDX_W-1:0];
    sidx_in = s5[SIDX_W-1:0];
    base_in = ADDR_W'(int'(sidx_in) * SET_DEPTH);
    cnt_in  = (in_if.step_count < 16'd2) ? 16'd2 : in_if.step_count;
    if (in_if.set_length == 5'd0) begin
      len_in = LEN_W'(1);
    end else if (int'(in_if.set_length) > SET_DEPTH) begin
      len_in = LEN_W'(SET_DEPTH);
    end else begin
      len_in = LEN_W'(in_if.set_length);
    end
  end

  always_comb begin
    lo_r    = rlo_q[ridx_q];
    hi_r    = rhi_q[ridx_q];
    st_r    = rstep_q[ridx_q];
    below_r = v_q - val_t'(div_rsp.rem);
    gap_r   = VALUE_WIDTH'(hi_r - below_r);
    above_r = (st_r > gap_r) ? hi_r : below_r + val_t'(st_r);
    q_r     = (div_rsp.quot == '0) ? VALUE_WIDTH'(1) : div_rsp.quot;
    ent     = val_t'(ram_rdata);
  end

  always_comb begin
    state_d = state_q;
    v_d = v_q; up_d = up_q; ridx_d = ridx_q; sbase_d = sbase_q; n_d = n_q;
    step_d = step_q; t0_d = t0_q; tl_d = tl_q; below_d = below_q;
    i_d = i_q; res_d = res_q; stat_d = stat_q;
    div_req = '0;
    wr_len = 1'b0;
    ram_we = 1'b0;
    ram_waddr = ADDR_W'(int'(base_in) + int'(in_if.entry_index));
    ram_raddr = sbase_q;
    ov_d = ov_q && !out_if.ready;
    unique case (state_q)
      ST_IDLE: begin
        v_d     = in_if.value;
        up_d    = in_if.range_upper;
        ridx_d  = ridx_in;
        sbase_d = base_in;
        n_d     = slen_q[sidx_in];
        ram_raddr = base_in;
        stat_d  = 1'b0;
        if (in_acc) begin
          unique case (req_type_e'(in_if.req_type))
            REQ_LOAD_RANGE: begin
              if (is_rng) begin
                step_d = VALUE_WIDTH'(1);
                if (in_if.range_upper > in_if.value) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = VALUE_WIDTH'(in_if.range_upper - in_if.value);
                  div_req.divisor  = VALUE_WIDTH'(cnt_in - 16'd1);
                  state_d = ST_DIV_LOAD;
                end else begin
                  state_d = ST_RNG_WR;
                end
              end
            end
            REQ_LOAD_LEN: wr_len = is_set;
            REQ_LOAD_ENTRY: ram_we = is_set && (int'(in_if.entry_index) < SET_DEPTH);
            REQ_QUANTIZE: begin
              if (is_rng) begin
                if (in_if.value <= rlo_q[ridx_in]) begin
                  res_d = rlo_q[ridx_in];
                  state_d = ST_FINISH;
                end else if (in_if.value >= rhi_q[ridx_in]) begin
                  res_d = rhi_q[ridx_in];
                  state_d = ST_FINISH;
                end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = VALUE_WIDTH'(in_if.value - rlo_q[ridx_in]);
                  div_req.divisor  = (rstep_q[ridx_in] == '0) ? VALUE_WIDTH'(1)
                                                              : rstep_q[ridx_in];
                  state_d = ST_DIV_QUANT;
                end
              end else if (is_set) begin
                state_d = ST_SET_T0;
              end else begin
                res_d   = in_if.value;
                stat_d  = 1'b1;
                state_d = ST_FINISH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV_LOAD: begin
        if (div_rsp.done) begin
          step_d  = q_r;
          state_d = ST_RNG_WR;
        end
      end
      ST_RNG_WR: state_d = ST_IDLE;
      ST_DIV_QUANT: begin
        if (div_rsp.done) begin
          res_d   = (div_rsp.rem == '0) ? v_q : pick_nearer(v_q, below_r, above_r);
          state_d = ST_FINISH;
        end
      end
      ST_SET_T0: begin
        t0_d      = ent;
        ram_raddr = ADDR_W'(int'(sbase_q) + int'(n_q) - 1);
        state_d   = ST_SET_TL;
      end
      ST_SET_TL: begin
        tl_d = ent;
        if (v_q <= t0_q) begin
          res_d   = t0_q;
          state_d = ST_FINISH;
        end else if (v_q >= ent) begin
          res_d   = ent;
          state_d = ST_FINISH;
        end else begin
          below_d   = t0_q;
          i_d       = EIDX_W'(1);
          ram_raddr = ADDR_W'(int'(sbase_q) + 1);
          state_d   = ST_SET_SCAN;
        end
      end
      ST_SET_SCAN: begin
        if (ent == v_q) begin
          res_d   = v_q;
          state_d = ST_FINISH;
        end else if (ent > v_q) begin
          res_d   = pick_nearer(v_q, below_q, ent);
          state_d = ST_FINISH;
        end else if (int'(i_q) == int'(n_q) - 1) begin
          res_d   = tl_q;
          state_d = ST_FINISH;
        end else begin
          below_d   = ent;
          i_d       = i_q + 1'b1;
          ram_raddr = ADDR_W'(int'(sbase_q) + int'(i_q) + 1);
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!ov_q || out_if.ready) begin
          ov_d    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ov_q        <= 1'b0;
      range_cnt_q <= '0;
      set_cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      if (cfg_we_i && cfg_idx_i == REG_RANGE_DIM_COUNT) begin
        range_cnt_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == REG_SET_DIM_COUNT) begin
        set_cnt_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d; up_q <= up_d; ridx_q <= ridx_d; sbase_q <= sbase_d; n_q <= n_d;
    step_q <= step_d; t0_q <= t0_d; tl_q <= tl_d; below_q <= below_d;
    i_q <= i_d; res_q <= res_d; stat_q <= stat_d;
    if (state_q == ST_RNG_WR) begin
      rlo_q[ridx_q]   <= v_q;
      rhi_q[ridx_q]   <= up_q;
      rstep_q[ridx_q] <= step_q;
    end
    if (wr_len) begin
      slen_q[sidx_in] <= len_in;
    end
    if (state_q == ST_FINISH && ov_d && !(ov_q && !out_if.ready)) begin
      oq_q  <= res_q;
      ost_q <= stat_q;
    end
  end

  assign out_if.valid     = ov_q;
  assign out_if.quantized = oq_q;
  assign out_if.status    = ost_q;

  gvq_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  gvq_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (VALUE_WIDTH'(in_if.value)),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );
endmodule
`default_nettype wire

FILE: rtl/gvq_checker.sv
// ----------------------------------------------------------------------------
// gvq_checker
// Port-level checks of the grid value quantizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module gvq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] quantized,
  input wire logic        status
);
  // a shown result carries known values
  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !$isunknown({quantized, status}))
    else $error("result carries unknown bits");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(quantized) && $stable(status)))
    else $error("stalled result changed");

  // no result shows during reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("result valid in reset");

  // ready is driven to a known level whenever a request is valid
  a_ready_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid |-> !$isunknown(in_ready))
    else $error("request ready unknown");
endmodule

bind grid_value_quantizer_unit gvq_checker u_gvq_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .quantized (out_if.quantized),
  .status    (out_if.status)
);
`default_nettype wire
